FILE: rtl/rfr_pkg.sv
package rfr_pkg;

    // Fixed field widths
    localparam int COEF_BITS = 18;
    localparam int COEF_FRAC = 16;
    localparam int FACTOR_BITS = 5;
    localparam int TAPCNT_BITS = 9;
    localparam int INDEX_BITS = 8;
    localparam int PHASE_BITS = 4;
    localparam int PHASE_MOD = 1 << PHASE_BITS;

    // Default sizes
    localparam int DEF_MAX_TAPS = 256;
    localparam int DEF_MAX_FACTOR = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Register map
    localparam int ADDR_BITS = 4;
    localparam logic [1:0] REG_UP_FACTOR = 2'd0;
    localparam logic [1:0] REG_DOWN_FACTOR = 2'd1;
    localparam logic [1:0] REG_TAP_COUNT = 2'd2;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

endpackage

FILE: rtl/rational_fir_resampler_top.sv
// Coefficient write: no result.
// Sample input: p upsampled samples enter the history, where p is the up factor, giving
// K (0..p) kept outputs, each a MAC over T taps with T the tap count; a stalled result holds up the item.
// Reset: async, active low; then a clearing pass zeroes all 2**clog2(MAX_TAPS) entries of the
// sample history, with the item channel stalled (register writes are taken throughout).
module rational_fir_resampler_top #(
    parameter int MAX_TAPS = rfr_pkg::DEF_MAX_TAPS,
    parameter int MAX_FACTOR = rfr_pkg::DEF_MAX_FACTOR,
    parameter int SAMPLE_BITS = rfr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  cmd,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic [rfr_pkg::INDEX_BITS-1:0]        coef_index,
    input  logic signed [rfr_pkg::COEF_BITS-1:0]  coef_value,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [SAMPLE_BITS-1:0]         out_sample,
    output logic                                  last,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rfr_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import rfr_pkg::*;

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int HIST_DEPTH = 1 << AW;
    localparam int CIW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int IW = $clog2(MAX_FACTOR);
    localparam int ACC_BITS = COEF_BITS + SAMPLE_BITS + AW + 1;
    localparam int SCW = ACC_BITS + FW + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PUSH  = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_ROUND = 3'd6;

    // Configuration registers
    logic [FACTOR_BITS-1:0] up_reg;
    logic [FACTOR_BITS-1:0] down_reg;
    logic [TAPCNT_BITS-1:0] taps_reg;

    // Sequencer state
    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [AW-1:0]         k_reg, k_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  rd_v_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SCW-1:0] scaled_reg;

    // Output register
    logic                          res_v_reg;
    logic signed [SAMPLE_BITS-1:0] res_data_reg;
    logic                          res_last_reg;

    // Memories
    logic signed [COEF_BITS-1:0]   coef_mem [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
    logic signed [COEF_BITS-1:0]   coef_q;
    logic signed [SAMPLE_BITS-1:0] hist_q;

    logic                          item_acc;
    logic                          coef_we;
    logic [CIW-1:0]                cidx_w;
    logic                          hist_we;
    logic [AW-1:0]                 hist_wa;
    logic signed [SAMPLE_BITS-1:0] hist_wd;
    logic [AW-1:0]                 hist_ra;

    logic [31:0]           p_w, q_w, qd_w, t_w;
    logic [FW-1:0]         p_eff;
    logic [PHASE_BITS:0]   ph_inc;
    logic                  last_i;
    logic                  last_res;
    logic                  res_load;
    logic                  issue;
    logic signed [SCW-1:0] rnd_v;
    logic signed [SCW-1:0] rnd_r;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                  out_free;

    mac_ctl_t                     mac_ctl;
    logic signed [ACC_BITS-1:0]   mac_acc;
    logic                         mac_busy;

    // Effective factors and tap count
    always_comb
    begin
        if (up_reg == '0)
            p_w = 32'd1;
        else if (32'(up_reg) > MAX_FACTOR)
            p_w = 32'(MAX_FACTOR);
        else
            p_w = 32'(up_reg);

        if (down_reg == '0)
            q_w = 32'd1;
        else if (32'(down_reg) > MAX_FACTOR)
            q_w = 32'(MAX_FACTOR);
        else
            q_w = 32'(down_reg);

        // keep period, limited by the phase counter wrap
        qd_w = (q_w > 32'(PHASE_MOD)) ? 32'(PHASE_MOD) : q_w;

        if (taps_reg == '0)
            t_w = 32'd1;
        else if (32'(taps_reg) > MAX_TAPS)
            t_w = 32'(MAX_TAPS);
        else
            t_w = 32'(taps_reg);
    end

    assign p_eff    = p_w[FW-1:0];
    assign ph_inc   = {1'b0, phase_reg} + 1'b1;
    assign last_i   = (32'(i_reg) == p_w - 32'd1);
    assign last_res = (32'(i_reg) + qd_w >= p_w);

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= FACTOR_BITS'(1);
            down_reg <= FACTOR_BITS'(1);
            taps_reg <= TAPCNT_BITS'(1);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_UP_FACTOR:   up_reg   <= pwdata[FACTOR_BITS-1:0];
                REG_DOWN_FACTOR: down_reg <= pwdata[FACTOR_BITS-1:0];
                REG_TAP_COUNT:   taps_reg <= pwdata[TAPCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_UP_FACTOR:   prdata = 32'(up_reg);
            REG_DOWN_FACTOR: prdata = 32'(down_reg);
            REG_TAP_COUNT:   prdata = 32'(taps_reg);
            default:         prdata = '0;
        endcase
    end

    // Item channel
    assign item_stall = (state_reg != ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign cidx_w     = CIW'(coef_index);
    assign coef_we    = item_acc && cmd && (32'(coef_index) < MAX_TAPS);

    // History write port: clearing pass or newest upsampled sample
    always_comb
    begin
        hist_we = 1'b0;
        hist_wa = wp_reg + 1'b1;
        hist_wd = (i_reg == '0) ? x_reg : '0;
        if (state_reg == ST_CLEAR)
        begin
            hist_we = 1'b1;
            hist_wa = clr_reg;
            hist_wd = '0;
        end
        else if (state_reg == ST_PUSH)
        begin
            hist_we = 1'b1;
        end
    end

    assign hist_ra = wp_reg - k_reg;

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[cidx_w[AW-1:0]] <= coef_value;
        coef_q <= coef_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        hist_q <= hist_mem[hist_ra];
    end

    // Round half up, then saturate
    assign rnd_v = scaled_reg + SCW'(1 << (COEF_FRAC - 1));
    assign rnd_r = rnd_v >>> COEF_FRAC;

    always_comb
    begin
        if ((rnd_r[SCW-1:SAMPLE_BITS-1] == '0) || (rnd_r[SCW-1:SAMPLE_BITS-1] == '1))
            sat_val = rnd_r[SAMPLE_BITS-1:0];
        else if (rnd_r[SCW-1])
            sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    assign out_free = !res_v_reg || !result_stall;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        wp_next       = wp_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        phase_next    = phase_reg;
        issue         = 1'b0;
        mac_ctl.clear = 1'b0;
        mac_ctl.valid = rd_v_reg;
        res_load      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_acc && !cmd)
                begin
                    i_next     = '0;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                wp_next = wp_reg + 1'b1;
                if (32'(ph_inc) >= q_w)
                    phase_next = '0;
                else
                    phase_next = ph_inc[PHASE_BITS-1:0];
                if (phase_reg == '0)
                begin
                    k_next        = '0;
                    mac_ctl.clear = 1'b1;
                    state_next    = ST_MAC;
                end
                else if (last_i)
                    state_next = ST_IDLE;
                else
                    i_next = i_reg + 1'b1;
            end
            ST_MAC:
            begin
                issue = 1'b1;
                if (32'(k_reg) == t_w - 32'd1)
                    state_next = ST_DRAIN;
                else
                    k_next = k_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !mac_busy)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (last_i)
                        state_next = ST_IDLE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_PUSH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            wp_reg    <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            phase_reg <= '0;
            rd_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            wp_reg    <= wp_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            phase_reg <= phase_next;
            rd_v_reg  <= issue;
            if (res_load)
                res_v_reg <= 1'b1;
            else if (!result_stall)
                res_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc && !cmd)
            x_reg <= sample;
        if (state_reg == ST_SCALE)
            scaled_reg <= mac_acc * $signed({1'b0, p_eff});
        if (res_load)
        begin
            res_data_reg <= sat_val;
            res_last_reg <= last_res;
        end
    end

    rfr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .coef  (coef_q),
        .hist  (hist_q),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    assign result_valid = res_v_reg;
    assign out_sample   = res_data_reg;
    assign last         = res_last_reg;

endmodule

FILE: rtl/rfr_mac.sv
module rfr_mac #(
    parameter int SAMPLE_BITS = rfr_pkg::DEF_SAMPLE_BITS,
    parameter int ACC_BITS = 42
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rfr_pkg::mac_ctl_t                     ctl,
    input  logic signed [rfr_pkg::COEF_BITS-1:0]  coef,
    input  logic signed [SAMPLE_BITS-1:0]         hist,
    output logic signed [ACC_BITS-1:0]            acc,
    output logic                                  busy
);
    import rfr_pkg::*;

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_v_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * hist;
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_v_reg;

endmodule
